FILE: design/hs_pkg.sv
// ----------------------------------------------------------------------------
// hs_pkg
// Shared types, codes and sizes of the health supervisor.
// ----------------------------------------------------------------------------
package hs_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int TIME_W      = 64;
    localparam int THR_W       = 63;
    localparam int OUT_CNT_W   = 32;
    localparam int REQ_W       = 3;
    localparam int HEALTH_W    = 3;
    localparam int CFG_IDX_W   = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_FRAME    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DROP     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_UPDATE   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CAMERA   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_LINK     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_NAV      = 3'd5;
    localparam logic [REQ_W-1:0] REQ_FAILSAFE = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SHUTDOWN = 3'd7;

    // health codes
    localparam logic [HEALTH_W-1:0] HS_BOOTING  = 3'd0;
    localparam logic [HEALTH_W-1:0] HS_READY    = 3'd1;
    localparam logic [HEALTH_W-1:0] HS_DEGRADED = 3'd2;
    localparam logic [HEALTH_W-1:0] HS_FAILSAFE = 3'd3;
    localparam logic [HEALTH_W-1:0] HS_SHUTDOWN = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_AGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LATENCY   = 2'd1;

    localparam logic [THR_W-1:0] MAX_FRAME_AGE_RST = 63'd100000000;
    localparam logic [THR_W-1:0] MAX_LATENCY_RST   = 63'd50000000;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [TIME_W-1:0] frame_time;
        logic [TIME_W-1:0] latency_in;
        logic [TIME_W-1:0] time_now;
        logic              flag_value;
    } t_item;

    typedef struct packed {
        logic [HEALTH_W-1:0]    health;
        logic [COUNT_WIDTH-1:0] seen;
        logic [COUNT_WIDTH-1:0] lost;
        logic [TIME_W-1:0]      last_stamp;
        logic [TIME_W-1:0]      last_lat;
        logic [TIME_W-1:0]      age;
        logic                   cam_ok;
        logic                   link_ok;
        logic                   nav_ok;
        logic                   fs_pend;
        logic                   sd_pend;
        logic                   have_frame;
    } t_state;

    typedef struct packed {
        logic [THR_W-1:0] max_age;
        logic [THR_W-1:0] max_lat;
    } t_thr;

endpackage

FILE: design/hs_channels.sv
// ----------------------------------------------------------------------------
// hs_channels
// Valid/ready channels of the health supervisor: events, results, config.
// ----------------------------------------------------------------------------
interface hs_in_if;
    logic                        valid;
    logic                        ready;
    logic [hs_pkg::REQ_W-1:0]    req_type;
    logic signed [hs_pkg::TIME_W-1:0] frame_time;
    logic signed [hs_pkg::TIME_W-1:0] latency_in;
    logic signed [hs_pkg::TIME_W-1:0] time_now;
    logic                        flag_value;

    modport source (output valid, req_type, frame_time, latency_in, time_now, flag_value,
                    input ready);
    modport sink   (input valid, req_type, frame_time, latency_in, time_now, flag_value,
                    output ready);
endinterface

interface hs_out_if;
    logic                             valid;
    logic                             ready;
    logic [hs_pkg::HEALTH_W-1:0]      health;
    logic signed [hs_pkg::TIME_W-1:0] frame_age;
    logic [hs_pkg::OUT_CNT_W-1:0]     seen_count;
    logic [hs_pkg::OUT_CNT_W-1:0]     dropped_count;

    modport source (output valid, health, frame_age, seen_count, dropped_count,
                    input ready);
    modport sink   (input valid, health, frame_age, seen_count, dropped_count,
                    output ready);
endinterface

interface hs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [hs_pkg::CFG_IDX_W-1:0]  index;
    logic [hs_pkg::TIME_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/hs_eval.sv
// ----------------------------------------------------------------------------
// hs_eval
// Next supervisor state for one event: counters, age and health machine.
// ----------------------------------------------------------------------------
module hs_eval (
    input  hs_pkg::t_state i_st,
    input  hs_pkg::t_item  i_item,
    input  hs_pkg::t_thr   i_thr,
    output hs_pkg::t_state o_st
);
    import hs_pkg::*;

    logic [TIME_W-1:0] w_age_upd;
    logic              w_stale;
    logic              w_slow;
    logic              w_bad;
    t_state            w_nx;

    assign w_age_upd = i_st.have_frame ? i_item.time_now - i_st.last_stamp : i_st.age;
    assign w_stale   = i_st.have_frame && !w_age_upd[TIME_W-1]
                       && (w_age_upd[THR_W-1:0] > i_thr.max_age);
    assign w_slow    = !i_st.last_lat[TIME_W-1] && (i_st.last_lat[THR_W-1:0] > i_thr.max_lat);
    assign w_bad     = !i_st.cam_ok || !i_st.link_ok || !i_st.nav_ok || w_stale || w_slow;

    always_comb begin
        w_nx = i_st;
        unique case (i_item.req_type)
            REQ_FRAME: begin
                w_nx.seen       = i_st.seen + COUNT_WIDTH'(1);
                w_nx.last_stamp = i_item.frame_time;
                w_nx.last_lat   = i_item.latency_in;
                w_nx.age        = i_item.time_now - i_item.frame_time;
                w_nx.have_frame = 1'b1;
            end
            REQ_DROP: begin
                w_nx.lost = i_st.lost + COUNT_WIDTH'(1);
                w_nx.age  = w_age_upd;
            end
            REQ_UPDATE: begin
                w_nx.age = w_age_upd;
                priority if (i_st.health == HS_SHUTDOWN) begin
                    w_nx.health = HS_SHUTDOWN;
                end else if (i_st.sd_pend) begin
                    w_nx.health = HS_SHUTDOWN;
                end else if (i_st.fs_pend) begin
                    w_nx.health = HS_FAILSAFE;
                end else if (i_st.health == HS_FAILSAFE) begin
                    w_nx.health = HS_FAILSAFE;
                end else if (i_st.health == HS_BOOTING && !i_st.have_frame) begin
                    w_nx.health = HS_BOOTING;
                end else begin
                    w_nx.health = w_bad ? HS_DEGRADED : HS_READY;
                end
            end
            REQ_CAMERA:   w_nx.cam_ok  = i_item.flag_value;
            REQ_LINK:     w_nx.link_ok = i_item.flag_value;
            REQ_NAV:      w_nx.nav_ok  = i_item.flag_value;
            REQ_FAILSAFE: w_nx.fs_pend = 1'b1;
            REQ_SHUTDOWN: w_nx.sd_pend = 1'b1;
            default:      w_nx = i_st;
        endcase
    end

    assign o_st = w_nx;

endmodule

FILE: design/health_supervisor_fsm_unit.sv
// ----------------------------------------------------------------------------
// health_supervisor_fsm_unit
// Health supervisor: one event beat in, one status beat out.
// ----------------------------------------------------------------------------
// Each event beat is captured in an input register, evaluated against the
// supervisor state and the two thresholds, and its status beat lands in an
// output register once that register is empty or its beat is taken; a new
// event is accepted every cycle as long as the result side takes beats. The
// combinational path from the input register through the 64-bit age
// subtraction and threshold compare to the state registers sets that
// one-beat-per-cycle figure. The config channel is always ready; write it
// only while no event is in flight.
module health_supervisor_fsm_unit (
    input  logic     i_clk,
    input  logic     i_rst_n,
    hs_in_if.sink    i_in,
    hs_cfg_if.sink   i_cfg,
    hs_out_if.source o_res
);
    import hs_pkg::*;

    t_item  r_in;
    logic   r_in_vld;
    t_state r_st;
    t_state n_st;
    t_thr   r_thr;
    logic   r_out_vld;
    logic [HEALTH_W-1:0]  r_health;
    logic [TIME_W-1:0]    r_age;
    logic [OUT_CNT_W-1:0] r_seen;
    logic [OUT_CNT_W-1:0] r_lost;
    logic   w_adv;

    assign w_adv      = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_in.ready = !r_in_vld || w_adv;
    assign i_cfg.ready = 1'b1;

    hs_eval u_eval (
        .i_st   (r_st),
        .i_item (r_in),
        .i_thr  (r_thr),
        .o_st   (n_st)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.req_type   <= i_in.req_type;
            r_in.frame_time <= i_in.frame_time;
            r_in.latency_in <= i_in.latency_in;
            r_in.time_now   <= i_in.time_now;
            r_in.flag_value <= i_in.flag_value;
        end
    end

    // thresholds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.max_age <= MAX_FRAME_AGE_RST;
            r_thr.max_lat <= MAX_LATENCY_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_MAX_FRAME_AGE: r_thr.max_age <= i_cfg.data[THR_W-1:0];
                CFG_MAX_LATENCY:   r_thr.max_lat <= i_cfg.data[THR_W-1:0];
                default:           r_thr         <= r_thr;
            endcase
        end
    end

    // supervisor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (w_adv) begin
            r_st <= n_st;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_health <= n_st.health;
            r_age    <= n_st.age;
            r_seen   <= OUT_CNT_W'(n_st.seen);
            r_lost   <= OUT_CNT_W'(n_st.lost);
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.health        = r_health;
    assign o_res.frame_age     = r_age;
    assign o_res.seen_count    = r_seen;
    assign o_res.dropped_count = r_lost;

endmodule

FILE: design/hs_checker.sv
// ----------------------------------------------------------------------------
// hs_checker
// Port-level checks of the health supervisor, bound to the top level.
// ----------------------------------------------------------------------------
module hs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [hs_pkg::HEALTH_W-1:0]   i_health,
    input logic [hs_pkg::OUT_CNT_W-1:0]  i_seen_count
);
    import hs_pkg::*;

    logic                 r_sd_seen;
    logic                 r_any_beat;
    logic [OUT_CNT_W-1:0] r_last_seen;
    logic [OUT_CNT_W-1:0] w_seen_step;

    assign w_seen_step = i_seen_count - r_last_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd_seen   <= 1'b0;
            r_any_beat  <= 1'b0;
            r_last_seen <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_sd_seen   <= r_sd_seen || (i_health == HS_SHUTDOWN);
            r_any_beat  <= 1'b1;
            r_last_seen <= i_seen_count;
        end
    end

    a_health_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_health <= HS_SHUTDOWN))
        else $error("health code out of range");

    a_shutdown_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && r_sd_seen) |-> (i_health == HS_SHUTDOWN))
        else $error("health left shutdown");

    a_seen_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && r_any_beat)
            |-> (COUNT_WIDTH'(w_seen_step) == '0 || COUNT_WIDTH'(w_seen_step) == 1))
        else $error("seen count jumped by more than one");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_health)))
        else $error("stalled result beat changed");

endmodule

bind health_supervisor_fsm_unit hs_checker u_hs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_health     (o_res.health),
    .i_seen_count (o_res.seen_count)
);
